FILE: hw/rtl/mbb_pkg.sv
// ----------------------------------------------------------------------------
// mbb_pkg
// Shared types and constants for the monochrome bitmap blitter.
// ----------------------------------------------------------------------------
package mbb_pkg;

  // Coordinate bound; the field widths below already cover it
  localparam int unsigned MaxSide = 1024;

  // Depth of the queue between the front and back parts
  localparam int unsigned FifoDepthDefault = 4;

  // Stream widths
  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 40;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgFbBase     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFbHeight   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPixelBytes = 2'd2;

  // Reset values
  localparam logic [31:0] FbBaseReset     = 32'd0;
  localparam logic [10:0] FbHeightReset   = 11'd240;
  localparam logic [2:0]  PixelBytesReset = 3'd3;

  // Bytes per pixel limits
  localparam logic [2:0] PixelBytesMin = 3'd2;
  localparam logic [2:0] PixelBytesMax = 3'd4;

  // Width of the per-pixel address step (fb_height * pixel_bytes)
  localparam int unsigned StepW = 14;

  // Configuration as seen by the front part
  typedef struct packed {
    logic [31:0] fb_base;
    logic [10:0] fb_height;
    logic [2:0]  pixel_bytes;
  } cfg_t;

  // One queued job: a bitmap byte reduced to a start address and a pixel mask
  typedef struct packed {
    logic [31:0]      addr0;   // address of the pixel for bit 0
    logic [StepW-1:0] step;    // address distance between adjacent pixels
    logic [7:0]       mask;    // mask[k] set: bitmap column k is drawn
    logic [31:0]      color;
    logic [2:0]       pb;      // effective bytes per pixel, 2 to 4
  } job_t;

endpackage

FILE: hw/rtl/mono_bitmap_blit_rotated_fb.sv
// ----------------------------------------------------------------------------
// mono_bitmap_blit_rotated_fb
// Expands 1-bit-per-pixel bitmap bytes into byte writes for a column-major,
// vertically flipped framebuffer.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one bitmap byte per transaction with its placement and
//   color. m_axis carries one framebuffer byte write per transaction;
//   tlast marks the final write caused by an input byte. A byte with no
//   drawn pixel causes no transaction at all.
//   cfg_we_i writes fb_base, fb_height or pixel_bytes; write only while
//   the block is idle. Unused indexes are ignored.
// Path: the first write of a byte passes the front register, which loads
//   at the accept edge, then the queue, the job register and the output
//   register.
// Throughput: one output write per cycle while m_axis_tready is high;
//   an input byte makes (set valid bits) * pixel_bytes writes, up to 32;
//   the back part's single output port sets this. The front accepts one
//   byte per cycle while the job queue has room.
// Reset: registers return to fb_base 0, fb_height 240, pixel_bytes 3;
//   the queue and both pipelines are emptied.
// Stall: when m_axis_tready is low the output holds; the queue absorbs
//   FifoDepth jobs, and the front register one more byte, before s_axis_tready drops.
// ----------------------------------------------------------------------------
module mono_bitmap_blit_rotated_fb #(
  parameter int unsigned FifoDepth = mbb_pkg::FifoDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [mbb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]                  cfg_wdata_i,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // origin_x[9:0], origin_y[19:10], color[51:20], byte_column[58:52],
  // row[68:59], bitmap_byte[76:69], valid_bits[80:77], zero fill above
  input  logic [mbb_pkg::InDataW-1:0]  s_axis_tdata,
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // address[31:0], data[39:32]
  output logic [mbb_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tlast
);
  import mbb_pkg::*;

  cfg_t cfg_q;
  logic push, full, pop, empty;
  job_t push_job, pop_job;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fb_base     <= FbBaseReset;
      cfg_q.fb_height   <= FbHeightReset;
      cfg_q.pixel_bytes <= PixelBytesReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFbBase:     cfg_q.fb_base     <= cfg_wdata_i;
        CfgFbHeight:   cfg_q.fb_height   <= cfg_wdata_i[10:0];
        CfgPixelBytes: cfg_q.pixel_bytes <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  mbb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push_o        (push),
    .job_o         (push_job),
    .full_i        (full)
  );

  mbb_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (pop_job),
    .empty_o (empty)
  );

  mbb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (pop_job),
    .empty_i       (empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: hw/rtl/mbb_front.sv
// ----------------------------------------------------------------------------
// mbb_front
// Accepts bitmap bytes, builds the pixel mask and the start address, and
// hands jobs with at least one pixel to the queue. One register stage; the
// address is finished combinationally on the way into the queue.
// ----------------------------------------------------------------------------
module mbb_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mbb_pkg::cfg_t                cfg_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // origin_x[9:0], origin_y[19:10], color[51:20], byte_column[58:52],
  // row[68:59], bitmap_byte[76:69], valid_bits[80:77], zero fill above
  input  logic [mbb_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         push_o,
  output mbb_pkg::job_t                job_o,
  input  logic                         full_i
);
  import mbb_pkg::*;

  logic [9:0]  origin_x, origin_y, row;
  logic [31:0] color;
  logic [6:0]  byte_column;
  logic [7:0]  bitmap_byte;
  logic [3:0]  valid_bits;

  assign origin_x    = s_axis_tdata[9:0];
  assign origin_y    = s_axis_tdata[19:10];
  assign color       = s_axis_tdata[51:20];
  assign byte_column = s_axis_tdata[58:52];
  assign row         = s_axis_tdata[68:59];
  assign bitmap_byte = s_axis_tdata[76:69];
  assign valid_bits  = s_axis_tdata[80:77];

  // Stage A: coordinates, first multiply, pixel mask
  logic        a_valid_q;
  logic [22:0] prod_q;
  logic [31:0] hy_q;
  logic [7:0]  mask_q, mask_d;
  logic [31:0] color_q;
  logic [11:0] x0;
  logic [10:0] y;
  logic        advance, accept;

  assign x0 = {2'b00, origin_x} + {2'b00, byte_column, 3'b000};
  assign y  = {1'b0, origin_y} + {1'b0, row};

  // MSB of the byte is column 0; only the leading valid_bits count
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      mask_d[k] = bitmap_byte[7-k] && (4'(k) < valid_bits);
    end
  end

  assign advance       = a_valid_q && !full_i;
  assign s_axis_tready = !a_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      a_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q  <= 23'(x0 * cfg_i.fb_height);
      hy_q    <= {21'd0, cfg_i.fb_height} - 32'd1 - {21'd0, y};
      mask_q  <= mask_d;
      color_q <= color;
    end
  end

  // Stage B: scale by bytes per pixel and add the base
  logic [2:0]  pb;
  logic [31:0] sum;

  always_comb begin
    priority if (cfg_i.pixel_bytes < PixelBytesMin) begin
      pb = PixelBytesMin;
    end else if (cfg_i.pixel_bytes > PixelBytesMax) begin
      pb = PixelBytesMax;
    end else begin
      pb = cfg_i.pixel_bytes;
    end
  end

  assign sum = {9'd0, prod_q} + hy_q;

  always_comb begin
    job_o.addr0 = cfg_i.fb_base + 32'(sum * {29'd0, pb});
    job_o.step  = StepW'(cfg_i.fb_height * pb);
    job_o.mask  = mask_q;
    job_o.color = color_q;
    job_o.pb    = pb;
  end

  // A byte with no pixel to draw is dropped here
  assign push_o = advance && (mask_q != 8'd0);

endmodule

FILE: hw/rtl/mbb_fifo.sv
// ----------------------------------------------------------------------------
// mbb_fifo
// Small job queue between the front and back parts.
// ----------------------------------------------------------------------------
module mbb_fifo #(
  parameter int unsigned Depth = mbb_pkg::FifoDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mbb_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output mbb_pkg::job_t job_o,
  output logic          empty_o
);
  import mbb_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    if (p == PtrW'(Depth - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/mbb_back.sv
// ----------------------------------------------------------------------------
// mbb_back
// Walks the pixel mask of each job and emits one byte write per cycle,
// while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module mbb_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mbb_pkg::job_t                job_i,
  input  logic                         empty_i,
  output logic                         pop_o,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // address[31:0], data[39:32]
  output logic [mbb_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tlast
);
  import mbb_pkg::*;

  logic        busy_q;
  job_t        job_q;
  logic [7:0]  rem_q, rem_d;
  logic [1:0]  byte_q;
  logic [2:0]  k;
  logic        last_byte, last_pixel, produce, finish, load;
  logic [31:0] addr;
  logic [7:0]  data;

  logic        out_valid_q;
  logic [31:0] out_addr_q;
  logic [7:0]  out_data_q;
  logic        out_last_q;

  // Lowest remaining column
  always_comb begin
    k = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (rem_q[i]) k = 3'(i);
    end
  end

  assign rem_d      = rem_q & (rem_q - 8'd1);
  assign last_pixel = (rem_d == 8'd0);
  assign last_byte  = ({1'b0, byte_q} == job_q.pb - 3'd1);

  assign produce = busy_q && (!out_valid_q || m_axis_tready);
  assign finish  = produce && last_byte && last_pixel;
  assign load    = (!busy_q || finish) && !empty_i;
  assign pop_o   = load;

  assign addr = job_q.addr0 + {15'd0, 17'(k * job_q.step)} + {30'd0, byte_q};

  always_comb begin
    unique case (byte_q)
      2'd0:    data = job_q.color[7:0];
      2'd1:    data = job_q.color[15:8];
      2'd2:    data = job_q.color[23:16];
      default: data = job_q.color[31:24];
    endcase
  end

  // Job walker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rem_q  <= 8'd0;
      byte_q <= 2'd0;
    end else if (load) begin
      busy_q <= 1'b1;
      rem_q  <= job_i.mask;
      byte_q <= 2'd0;
    end else if (produce) begin
      if (last_byte) begin
        byte_q <= 2'd0;
        rem_q  <= rem_d;
        if (last_pixel) busy_q <= 1'b0;
      end else begin
        byte_q <= byte_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) job_q <= job_i;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (produce) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      out_addr_q <= addr;
      out_data_q <= data;
      out_last_q <= last_byte && last_pixel;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_data_q, out_addr_q};
  assign m_axis_tlast  = out_last_q;

endmodule
